[design/uqd_pkg.sv]
// Package with the shared constants, codes and types of the unique-key deque.
`timescale 1ns / 1ps

package uqd_pkg;

  // Number of cells in the chain, and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Request codes.
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Cell operation codes.
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;
  localparam logic [1:0] OP_RIGHT = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  // One stored pair.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] data;
  } entry_t;

  // Control that the sequencer sends to one cell.
  typedef struct packed {
    logic [1:0] op;
    logic       occupied;
  } cell_ctrl_t;

endpackage

[design/uqd_req_if.sv]
// Request and response channel interfaces of the unique-key deque.
`timescale 1ns / 1ps

interface uqd_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] entry_key;
  logic signed [31:0] entry_data;

  modport source (output valid, output req_type, output entry_key, output entry_data,
                  input ready);
  modport sink (input valid, input req_type, input entry_key, input entry_data,
                output ready);
endinterface

interface uqd_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [31:0]        removed_key;
  logic signed [31:0]        removed_data;
  logic [uqd_pkg::CNT_W-1:0] occupancy;

  modport source (output valid, output status, output removed_key, output removed_data,
                  output occupancy, input ready);
  modport sink (input valid, input status, input removed_key, input removed_data,
                input occupancy, output ready);
endinterface

[design/unique_key_deque.sv]
// Top level of the unique-key deque: request sequencer, chain of cells and response register.
`timescale 1ns / 1ps

// Channel  Modport  Payload                                          Role
// req      sink     req_type, entry_key, entry_data                  incoming request
// rsp      source   status, removed_key, removed_data, occupancy     one response per request
//
// Each request is handled in an accept cycle, which compares the key against every cell of the
// chain at once, and a commit state, which shifts or loads the chain and writes the response.
// A new request can be accepted in the cycle after the previous one commits.
// While the response register is still full and not taken, the commit waits.
// Synchronous reset empties the deque and drops any pending response.

module unique_key_deque (
  input logic         clk,
  input logic         rst,
  uqd_req_if.sink     req,
  uqd_rsp_if.source   rsp
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic                      state;
  logic [1:0]                req_type_q;
  uqd_pkg::entry_t           fresh;
  logic                      dup_q;
  logic [uqd_pkg::CNT_W-1:0] count;
  logic [uqd_pkg::CNT_W-1:0] count_next;

  uqd_pkg::entry_t     cell_q     [uqd_pkg::DEPTH];
  uqd_pkg::cell_ctrl_t cell_ctrl  [uqd_pkg::DEPTH];
  logic [uqd_pkg::DEPTH-1:0] cell_match;

  logic                      accept;
  logic                      commit;
  logic                      is_push;
  logic [1:0]                status_next;
  logic [uqd_pkg::CNT_W-1:0] count_m1;
  logic [uqd_pkg::IDX_W-1:0] tail_idx;
  logic [uqd_pkg::IDX_W-1:0] push_idx;
  uqd_pkg::entry_t           removed_next;

  // No request is taken while reset is held.
  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign commit    = (state == S_COMMIT) && (!rsp.valid || rsp.ready);

  assign is_push  = (req_type_q == uqd_pkg::REQ_PUSH_REAR) ||
                    (req_type_q == uqd_pkg::REQ_PUSH_FRONT);
  assign count_m1 = count - 1'b1;
  assign tail_idx = count_m1[uqd_pkg::IDX_W-1:0];
  assign push_idx = count[uqd_pkg::IDX_W-1:0];

  // Outcome of the pending request, count update and removed pair.
  always_comb begin
    status_next  = uqd_pkg::ST_OK;
    count_next   = count;
    removed_next = '0;
    if (is_push) begin
      if (dup_q) begin
        status_next = uqd_pkg::ST_DUP;
      end else if (count == uqd_pkg::CNT_W'(uqd_pkg::DEPTH)) begin
        status_next = uqd_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_next = uqd_pkg::ST_EMPTY;
      end else begin
        count_next = count_m1;
        if (req_type_q == uqd_pkg::REQ_POP_FRONT) begin
          removed_next = cell_q[0];
        end else begin
          removed_next = cell_q[tail_idx];
        end
      end
    end
  end

  // Per-cell control: occupancy from the count, shift or load on a successful commit.
  always_comb begin
    for (int i = 0; i < uqd_pkg::DEPTH; i++) begin
      cell_ctrl[i].occupied = (uqd_pkg::CNT_W'(i) < count);
      cell_ctrl[i].op       = uqd_pkg::OP_HOLD;
      if (commit && status_next == uqd_pkg::ST_OK) begin
        case (req_type_q)
          uqd_pkg::REQ_PUSH_FRONT: cell_ctrl[i].op = uqd_pkg::OP_LEFT;
          uqd_pkg::REQ_POP_FRONT:  cell_ctrl[i].op = uqd_pkg::OP_RIGHT;
          uqd_pkg::REQ_PUSH_REAR: begin
            if (push_idx == uqd_pkg::IDX_W'(i)) begin
              cell_ctrl[i].op = uqd_pkg::OP_LOAD;
            end
          end
          default: cell_ctrl[i].op = uqd_pkg::OP_HOLD;
        endcase
      end
    end
  end

  // The chain of cells; the front cell takes the new pair from its left side.
  for (genvar g = 0; g < uqd_pkg::DEPTH; g++) begin : g_cell
    uqd_pkg::entry_t left_in;
    uqd_pkg::entry_t right_in;
    if (g == 0) begin : g_head
      assign left_in = fresh;
    end else begin : g_body
      assign left_in = cell_q[g-1];
    end
    if (g == uqd_pkg::DEPTH - 1) begin : g_tail
      assign right_in = fresh;
    end else begin : g_inner
      assign right_in = cell_q[g+1];
    end
    uqd_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[g]),
      .left    (left_in),
      .right   (right_in),
      .fresh   (fresh),
      .cmp_key (req.entry_key),
      .entry   (cell_q[g]),
      .match   (cell_match[g])
    );
  end

  // Sequencer and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      if (accept) begin
        state <= S_COMMIT;
      end else if (commit) begin
        state <= S_IDLE;
        count <= count_next;
      end
    end
  end

  // Request capture; the duplicate check is taken against the chain at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_q <= req.req_type;
      fresh.key  <= req.entry_key;
      fresh.data <= req.entry_data;
      dup_q      <= |cell_match;
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status       <= status_next;
      rsp.removed_key  <= removed_next.key;
      rsp.removed_data <= removed_next.data;
      rsp.occupancy    <= count_next;
    end
  end

endmodule

[design/uqd_cell.sv]
// One cell of the deque chain: holds a pair, shifts it to a neighbor and compares its key.
`timescale 1ns / 1ps

module uqd_cell (
  input  logic                clk,
  input  uqd_pkg::cell_ctrl_t ctrl,
  input  uqd_pkg::entry_t     left,
  input  uqd_pkg::entry_t     right,
  input  uqd_pkg::entry_t     fresh,
  input  logic signed [31:0]  cmp_key,
  output uqd_pkg::entry_t     entry,
  output logic                match
);

  uqd_pkg::entry_t entry_next;

  // The key matches only while the cell holds a stored pair.
  assign match = ctrl.occupied && (entry.key == cmp_key);

  // Select where the cell takes its next pair from.
  always_comb begin
    unique case (ctrl.op)
      uqd_pkg::OP_LEFT:  entry_next = left;
      uqd_pkg::OP_RIGHT: entry_next = right;
      uqd_pkg::OP_LOAD:  entry_next = fresh;
      default:           entry_next = entry;
    endcase
  end

  // Pair register; its contents matter only while occupied.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
